// ----- design/assert_macros.svh -----
// Assertion macros shared by the transcoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define U2L_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked while out of reset.
`define U2L_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/u2l_pkg.sv -----
// Shared types and constants of the UTF-8 to Latin-1 transcoder.
package u2l_pkg;

    localparam int AddrW = 3;
    localparam int DataW = 32;

    // Register index as seen in paddr[2]
    localparam logic RegBypass = 1'b0;

    localparam logic [7:0]  StarByte  = 8'h2A;
    localparam logic [10:0] CpLow     = 11'h0A0;
    localparam logic [10:0] CpHigh    = 11'h0FF;

    typedef struct packed {
        logic       emit;
        logic [7:0] data;
        logic       last;
    } result_t;

endpackage

// ----- design/utf8_to_latin1_converter_core.sv -----
// UTF-8 to Latin-1 transcoder top level: APB register, input register and handshake.
// Accepts one UTF-8 byte per clock cycle while in_stall is low and delivers at most one
// Latin-1 word per byte: the byte lands in an input register, and one decode step runs
// between it and the result register. The first byte of a
// two-byte sequence and swallowed continuation bytes produce no word. A zero byte yields a
// word of 0 with last set and returns the decoder to idle. Register bypass at address 0
// passes bytes through unchanged; write it only while the block is idle.
`include "assert_macros.svh"

module utf8_to_latin1_converter_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [u2l_pkg::AddrW-1:0]   paddr,
    input  logic [u2l_pkg::DataW-1:0]   pwdata,
    output logic [u2l_pkg::DataW-1:0]   prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  in_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  out_byte,
    output logic                        last
);

    logic             bypass_reg;
    logic             hold_valid_reg;
    logic [7:0]       hold_byte_reg;
    logic             advance;
    logic             accept;
    u2l_pkg::result_t result;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && paddr[2] == u2l_pkg::RegBypass)
        begin
            bypass_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == u2l_pkg::RegBypass)
        begin
            prdata[0] = bypass_reg;
        end
    end

    // advance the held word unless its result has nowhere to go
    assign advance  = hold_valid_reg && (!result.emit || !out_valid || !out_stall);
    assign in_stall = hold_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            hold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_byte_reg <= in_byte;
        end
    end

    u2l_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .bypass  (bypass_reg),
        .fire    (advance),
        .byte_in (hold_byte_reg),
        .result  (result)
    );

    u2l_out_stage u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance && result.emit),
        .result (result),
        .stall  (out_stall),
        .valid  (out_valid),
        .data   (out_byte),
        .last   (last)
    );

    `U2L_ASSERT_NEXT(a_word_kept, clk, rst_n, hold_valid_reg && in_stall, hold_valid_reg && $stable(hold_byte_reg), "held input word lost while stalled")
    `U2L_ASSERT_NOW(a_stall_only_full, clk, rst_n, in_stall, out_valid && out_stall && result.emit, "input stalled with room downstream")

endmodule

// ----- design/u2l_decode.sv -----
// Character decoder: mode and pending lead byte, one input byte per cycle while fire is set.
`include "assert_macros.svh"

module u2l_decode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              bypass,
    input  logic              fire,
    input  logic [7:0]        byte_in,
    output u2l_pkg::result_t  result
);

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_SECOND = 2'd1,
        MODE_SKIP   = 2'd2
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [4:0]  lead_reg, lead_next;
    logic [10:0] cp;

    assign cp = {lead_reg, byte_in[5:0]};

    always_comb
    begin
        mode_next   = mode_reg;
        lead_next   = lead_reg;
        result.emit = 1'b1;
        result.data = byte_in;
        result.last = 1'b0;

        if (bypass)
        begin
            result.last = (byte_in == 8'h00);
            if (byte_in == 8'h00)
            begin
                mode_next = MODE_IDLE;
            end
        end
        else if (mode_reg == MODE_SECOND)
        begin
            mode_next = MODE_IDLE;
            if (byte_in == 8'h00)
            begin
                // drop the incomplete character
                result.last = 1'b1;
            end
            else if (cp < u2l_pkg::CpLow || cp > u2l_pkg::CpHigh)
            begin
                result.data = u2l_pkg::StarByte;
            end
            else
            begin
                result.data = cp[7:0];
            end
        end
        else if (mode_reg == MODE_SKIP && byte_in != 8'h00 && byte_in[7:6] == 2'b10)
        begin
            result.emit = 1'b0;
        end
        else
        begin
            // start of a new character
            if (byte_in == 8'h00)
            begin
                mode_next   = MODE_IDLE;
                result.last = 1'b1;
            end
            else if (!byte_in[7])
            begin
                mode_next = MODE_IDLE;
            end
            else if (byte_in[7:5] == 3'b110)
            begin
                mode_next   = MODE_SECOND;
                lead_next   = byte_in[4:0];
                result.emit = 1'b0;
            end
            else
            begin
                mode_next   = MODE_SKIP;
                result.data = u2l_pkg::StarByte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            lead_reg <= 5'd0;
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            lead_reg <= lead_next;
        end
    end

    `U2L_ASSERT_NEXT(a_last_to_idle, clk, rst_n, fire && result.emit && result.last, mode_reg == MODE_IDLE, "terminator did not return decoder to idle")
    `U2L_ASSERT_NOW(a_second_emits, clk, rst_n, fire && !bypass && mode_reg == MODE_SECOND, result.emit, "second byte of a pair produced no word")
    `U2L_ASSERT_NEXT(a_lead_held, clk, rst_n, fire && !bypass && mode_reg == MODE_IDLE && byte_in[7:5] == 3'b110, mode_reg == MODE_SECOND && lead_reg == $past(byte_in[4:0]), "lead byte not held")

endmodule

// ----- design/u2l_out_stage.sv -----
// Result register on the output channel.
`include "assert_macros.svh"

module u2l_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  u2l_pkg::result_t  result,
    input  logic              stall,
    output logic              valid,
    output logic [7:0]        data,
    output logic              last
);

    logic       valid_reg;
    logic [7:0] data_reg;
    logic       last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result.data;
            last_reg <= result.last;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;
    assign last  = last_reg;

    `U2L_ASSERT_NOW(a_last_is_zero, clk, rst_n, valid_reg && last_reg, data_reg == 8'h00, "terminator word carries a nonzero byte")
    `U2L_ASSERT_NOW(a_no_overwrite, clk, rst_n, valid_reg && stall, !load, "pending word overwritten while stalled")

endmodule
